// File: hdl/blr_pkg.sv
// Shared types, constants and state codes for the Bresenham line rasterizer.
package blr_pkg;

	// Widest coordinate the ports carry; COORD_BITS may be set at or below it
	localparam int COORD_MAX_BITS = 6;
	localparam int COORD_BITS_DEFAULT = 6;
	localparam int COLOUR_BITS = 32;

	// Entries in the command queue between classifier and stepper (power of two)
	localparam int QUEUE_DEPTH = 2;

	// Line command, one per input transaction
	typedef struct packed {
		logic [COORD_MAX_BITS-1:0] start_x;
		logic [COORD_MAX_BITS-1:0] start_y;
		logic [COORD_MAX_BITS-1:0] end_x;
		logic [COORD_MAX_BITS-1:0] end_y;
		logic [COLOUR_BITS-1:0]    draw_colour;
	} blr_in_t;

	// One pixel, one per output transaction
	typedef struct packed {
		logic [COORD_MAX_BITS-1:0] pixel_x;
		logic [COORD_MAX_BITS-1:0] pixel_y;
		logic [COLOUR_BITS-1:0]    pixel_colour;
		logic                      last_pixel;
	} blr_out_t;

	// Classified command: endpoints already in major/minor order
	typedef struct packed {
		logic [COORD_MAX_BITS-1:0] major_start;
		logic [COORD_MAX_BITS-1:0] major_end;
		logic [COORD_MAX_BITS-1:0] minor_start;
		logic [COORD_MAX_BITS-1:0] major_delta;
		logic [COORD_MAX_BITS-1:0] minor_delta;
		logic                      minor_dir_down;
		logic                      steep;
		logic [COLOUR_BITS-1:0]    colour;
	} blr_cmd_t;

	// Stepper states
	typedef enum logic {
		BLR_IDLE,
		BLR_RUN
	} blr_state_t;

endpackage

// File: hdl/blr_front.sv
// Front end: accepts line commands and sorts them into major/minor form.
module blr_front import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic     in_valid,
	output logic     in_ready,
	input  blr_in_t  in_data,
	input  logic     queue_full,
	output logic     push,
	output blr_cmd_t push_data
);

	localparam int CB = COORD_BITS;

	logic [CB-1:0] x0, y0, x1, y1;
	logic [CB-1:0] adx, ady;
	logic          steep;
	logic [CB-1:0] a0, b0, a1, b1;
	logic [CB-1:0] ma0, mb0, ma1, mb1;

	// Accept whenever the queue has room
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	assign x0 = in_data.start_x[CB-1:0];
	assign y0 = in_data.start_y[CB-1:0];
	assign x1 = in_data.end_x[CB-1:0];
	assign y1 = in_data.end_y[CB-1:0];

	// Spans and steepness; equal spans walk along x
	assign adx   = (x0 > x1) ? (x0 - x1) : (x1 - x0);
	assign ady   = (y0 > y1) ? (y0 - y1) : (y1 - y0);
	assign steep = ady > adx;

	assign a0 = steep ? y0 : x0;
	assign b0 = steep ? x0 : y0;
	assign a1 = steep ? y1 : x1;
	assign b1 = steep ? x1 : y1;

	// Order endpoints so the major coordinate rises
	always_comb begin
		if (a0 > a1) begin
			ma0 = a1;
			mb0 = b1;
			ma1 = a0;
			mb1 = b0;
		end else begin
			ma0 = a0;
			mb0 = b0;
			ma1 = a1;
			mb1 = b1;
		end
	end

	always_comb begin
		push_data.major_start    = COORD_MAX_BITS'(ma0);
		push_data.major_end      = COORD_MAX_BITS'(ma1);
		push_data.minor_start    = COORD_MAX_BITS'(mb0);
		push_data.major_delta    = COORD_MAX_BITS'(ma1 - ma0);
		push_data.minor_delta    = COORD_MAX_BITS'((mb0 > mb1) ? (mb0 - mb1) : (mb1 - mb0));
		push_data.minor_dir_down = mb1 < mb0;
		push_data.steep          = steep;
		push_data.colour         = in_data.draw_colour;
	end

endmodule

// File: hdl/blr_queue.sv
// Short show-ahead queue of classified commands between front and stepper.
module blr_queue import blr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  blr_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     cmd_valid,
	output blr_cmd_t cmd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	blr_cmd_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign cmd_valid = count_q != '0;
	assign cmd_data  = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: hdl/blr_back.sv
// Back end: steps the Bresenham decision term and emits one pixel per cycle while the output is not stalled.
module blr_back import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  blr_cmd_t cmd_data,
	output logic     cmd_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output blr_out_t out_data
);

	localparam int CB = COORD_BITS;
	localparam int ERR_W = CB + 2;

	blr_state_t state_q, state_d;

	logic [CB-1:0]           major_pos_q, major_end_q, minor_pos_q;
	logic [CB-1:0]           major_delta_q, minor_delta_q;
	logic                    minor_dir_down_q, steep_q;
	logic [COLOUR_BITS-1:0]  colour_q;
	logic signed [ERR_W-1:0] step_error_q;

	logic                    out_valid_q;
	blr_out_t                out_data_q;

	logic                    emit, last;
	logic [CB-1:0]           ld_major_delta, ld_minor_delta;
	logic signed [ERR_W-1:0] two_minor, two_major, ld_minor2, ld_major1;

	assign last = major_pos_q == major_end_q;
	assign emit = (state_q == BLR_RUN) && (!out_valid_q || out_ready);

	// Next state and queue pop; a new command loads as the last pixel leaves
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			BLR_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = BLR_RUN;
				end
			end
			BLR_RUN: begin
				if (emit && last) begin
					if (cmd_valid) cmd_pop = 1'b1;
					else state_d = BLR_IDLE;
				end
			end
			default: state_d = BLR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BLR_IDLE;
		else state_q <= state_d;
	end

	// Decision term increments
	assign ld_major_delta = cmd_data.major_delta[CB-1:0];
	assign ld_minor_delta = cmd_data.minor_delta[CB-1:0];
	assign ld_minor2      = {1'b0, ld_minor_delta, 1'b0};
	assign ld_major1      = {2'b00, ld_major_delta};
	assign two_minor      = {1'b0, minor_delta_q, 1'b0};
	assign two_major      = {1'b0, major_delta_q, 1'b0};

	// Line walker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q      <= '0;
			major_end_q      <= '0;
			minor_pos_q      <= '0;
			major_delta_q    <= '0;
			minor_delta_q    <= '0;
			minor_dir_down_q <= 1'b0;
			steep_q          <= 1'b0;
			colour_q         <= '0;
			step_error_q     <= '0;
		end else if (cmd_pop) begin
			major_pos_q      <= cmd_data.major_start[CB-1:0];
			major_end_q      <= cmd_data.major_end[CB-1:0];
			minor_pos_q      <= cmd_data.minor_start[CB-1:0];
			major_delta_q    <= ld_major_delta;
			minor_delta_q    <= ld_minor_delta;
			minor_dir_down_q <= cmd_data.minor_dir_down;
			steep_q          <= cmd_data.steep;
			colour_q         <= cmd_data.colour;
			step_error_q     <= ld_minor2 - ld_major1;
		end else if (emit && !last) begin
			major_pos_q <= major_pos_q + 1'b1;
			if (step_error_q > 0) begin
				minor_pos_q  <= minor_dir_down_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
				step_error_q <= step_error_q + two_minor - two_major;
			end else begin
				step_error_q <= step_error_q + two_minor;
			end
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Output register: pixel payload, swapped back for steep lines
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.pixel_x      <= COORD_MAX_BITS'(steep_q ? minor_pos_q : major_pos_q);
			out_data_q.pixel_y      <= COORD_MAX_BITS'(steep_q ? major_pos_q : minor_pos_q);
			out_data_q.pixel_colour <= colour_q;
			out_data_q.last_pixel   <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: hdl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: classifier, command queue and stepper.
//
// Each line command is walked along its major axis from the lower to the upper end and
// produces N pixel transactions, N = major span + 1 (1 to 2^COORD_BITS), one per cycle
// when the output is not stalled; the last carries last_pixel. The stepper sets the rate:
// it loads a command when it is idle, and loads the next queued command in the same cycle
// the final pixel of a line is registered, so queued lines follow with no gap. A two-entry
// command queue lets new commands be accepted while a line is drawn. Coordinates are
// taken modulo 2^COORD_BITS.
module bresenham_line_rasterizer import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  blr_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output blr_out_t out_data
);

	logic     push, queue_full, cmd_valid, cmd_pop;
	blr_cmd_t push_data, cmd_data;

	// Classifier
	blr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// Command queue
	blr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd_data  (cmd_data)
	);

	// Line stepper
	blr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_data  (cmd_data),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hdl/blr_checker.sv
// Port-level checker for the line rasterizer, bound to the top level.
module blr_checker import blr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input blr_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input blr_out_t out_data
);

	logic mid_line;

	// A pixel transaction that does not end its line
	assign mid_line = out_valid && out_ready && !out_data.last_pixel;

	// A stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pixel changed while stalled");

	// Pixels of one line come back to back
	a_line_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		mid_line |=> out_valid)
		else $error("gap inside a line");

	// Colour is constant along a line
	a_line_colour: assert property (@(posedge clk) disable iff (!arst_n)
		mid_line |=> out_data.pixel_colour == $past(out_data.pixel_colour))
		else $error("colour changed inside a line");

	// Consecutive pixels are neighbors, never the same pixel
	a_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		mid_line |=>
			(out_data.pixel_x == $past(out_data.pixel_x) ||
			 out_data.pixel_x == $past(out_data.pixel_x) + 6'd1 ||
			 out_data.pixel_x + 6'd1 == $past(out_data.pixel_x)) &&
			(out_data.pixel_y == $past(out_data.pixel_y) ||
			 out_data.pixel_y == $past(out_data.pixel_y) + 6'd1 ||
			 out_data.pixel_y + 6'd1 == $past(out_data.pixel_y)) &&
			!(out_data.pixel_x == $past(out_data.pixel_x) &&
			  out_data.pixel_y == $past(out_data.pixel_y)))
		else $error("pixels of a line not adjacent");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

// File: test/blr_line_checker.sv
// Checker for the line rasterizer: watches both channels, predicts every pixel and compares.
module blr_line_checker import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  blr_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  blr_out_t out_data,
	output int       fail_count,
	output int       pixels_pending,
	output int       pixels_checked
);

	localparam logic [COORD_MAX_BITS-1:0] COORD_MASK = COORD_MAX_BITS'((1 << COORD_BITS) - 1);

	// pixels still owed by the block, oldest first
	blr_out_t expected_pixels[$];

	function automatic int coord_span(logic [COORD_MAX_BITS-1:0] a, logic [COORD_MAX_BITS-1:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Walk one line command with the integer decision term and queue its pixels
	task automatic plot_line(input blr_in_t cmd);
		logic [COORD_MAX_BITS-1:0] x0, y0, x1, y1;
		logic [COORD_MAX_BITS-1:0] major_lo, major_hi, minor_lo, minor_hi;
		logic [COORD_MAX_BITS-1:0] major_at, minor_at;
		logic steep, falls, done;
		int major_span, minor_span, decision;
		blr_out_t pixel;
		x0 = cmd.start_x & COORD_MASK;
		y0 = cmd.start_y & COORD_MASK;
		x1 = cmd.end_x & COORD_MASK;
		y1 = cmd.end_y & COORD_MASK;
		// equal spans stay on the x axis
		steep = coord_span(y0, y1) > coord_span(x0, x1);
		if (steep) begin
			major_lo = y0; minor_lo = x0; major_hi = y1; minor_hi = x1;
		end else begin
			major_lo = x0; minor_lo = y0; major_hi = x1; minor_hi = y1;
		end
		// reversed endpoints: walk from the lower major end
		if (major_lo > major_hi) begin
			{major_lo, major_hi} = {major_hi, major_lo};
			{minor_lo, minor_hi} = {minor_hi, minor_lo};
		end
		major_span = int'(major_hi - major_lo);
		minor_span = coord_span(minor_lo, minor_hi);
		falls = minor_hi < minor_lo;
		decision = 2 * minor_span - major_span;
		major_at = major_lo;
		minor_at = minor_lo;
		done = 1'b0;
		while (!done) begin
			pixel.pixel_x = steep ? minor_at : major_at;
			pixel.pixel_y = steep ? major_at : minor_at;
			pixel.pixel_colour = cmd.draw_colour;
			pixel.last_pixel = (major_at == major_hi);
			expected_pixels.push_back(pixel);
			done = pixel.last_pixel;
			if (!done) begin
				if (decision > 0) begin
					minor_at = (falls ? minor_at - 1'b1 : minor_at + 1'b1) & COORD_MASK;
					decision += 2 * (minor_span - major_span);
				end else begin
					decision += 2 * minor_span;
				end
				major_at = (major_at + 1'b1) & COORD_MASK;
			end
		end
	endtask

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("pixel %0d: %s expected 0x%0h, got 0x%0h", pixels_checked, field, want, got);
		end
	endtask

	// Predict on accepted commands, compare on accepted pixels
	always @(posedge clk or negedge arst_n) begin
		blr_out_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			pixels_pending = 0;
		end else begin
			if (in_valid && in_ready)
				plot_line(in_data);
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected pixel (%0d,%0d) colour 0x%0h last %0b, no line pending",
							out_data.pixel_x, out_data.pixel_y, out_data.pixel_colour,
							out_data.last_pixel);
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_x", 32'(want.pixel_x), 32'(out_data.pixel_x));
					check_field("pixel_y", 32'(want.pixel_y), 32'(out_data.pixel_y));
					check_field("pixel_colour", want.pixel_colour, out_data.pixel_colour);
					check_field("last_pixel", 32'(want.last_pixel), 32'(out_data.last_pixel));
					pixels_checked++;
				end
			end
			pixels_pending = expected_pixels.size();
		end
	end

endmodule

// File: test/bresenham_line_rasterizer_tb.sv
// Testbench top for the line rasterizer: clock, reset, line commands, output stalls, verdict.
module bresenham_line_rasterizer_tb;
	import blr_pkg::*;

	localparam int RANDOM_LINES = 300;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     out_ready = 1'b0;
	blr_in_t  in_data = '0;
	logic     in_ready;
	logic     out_valid;
	blr_out_t out_data;

	int fail_count;
	int pixels_pending;
	int pixels_checked;

	blr_in_t line_queue[$];
	int      directed_count;
	int      burst_left;
	int      gap_len;

	logic [15:0] ready_pattern;
	int          pattern_life = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bresenham_line_rasterizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	blr_line_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.fail_count     (fail_count),
		.pixels_pending (pixels_pending),
		.pixels_checked (pixels_checked)
	);

	// Receiver stalls on a rotating pattern that is replaced by a new random one when its life runs out
	always @(negedge clk) begin
		if (pattern_life == 0) begin
			pattern_life = $urandom_range(40, 400);
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end
		out_ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		pattern_life--;
	end

	function automatic blr_in_t make_line(int x0, int y0, int x1, int y1, logic [31:0] colour);
		blr_in_t cmd;
		cmd.start_x = COORD_MAX_BITS'(x0);
		cmd.start_y = COORD_MAX_BITS'(y0);
		cmd.end_x = COORD_MAX_BITS'(x1);
		cmd.end_y = COORD_MAX_BITS'(y1);
		cmd.draw_colour = colour;
		return cmd;
	endfunction

	// coordinate within three of c, kept on the grid
	function automatic logic [5:0] near(logic [5:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v < 0) v = 0;
		if (v > 63) v = 63;
		return 6'(v);
	endfunction

	// Random command: free endpoints most often, else points, axis lines, diagonals, short lines
	function automatic blr_in_t random_line();
		blr_in_t cmd;
		int d;
		cmd.start_x = COORD_MAX_BITS'($urandom);
		cmd.start_y = COORD_MAX_BITS'($urandom);
		cmd.end_x = COORD_MAX_BITS'($urandom);
		cmd.end_y = COORD_MAX_BITS'($urandom);
		cmd.draw_colour = $urandom;
		case ($urandom_range(0, 9))
			0: begin
				cmd.end_x = cmd.start_x;
				cmd.end_y = cmd.start_y;
			end
			1: cmd.end_y = cmd.start_y;
			2: cmd.end_x = cmd.start_x;
			3: begin
				d = (cmd.end_x > cmd.start_x) ? int'(cmd.end_x - cmd.start_x)
					: int'(cmd.start_x - cmd.end_x);
				cmd.start_y = COORD_MAX_BITS'($urandom_range(0, 63 - d));
				cmd.end_y = COORD_MAX_BITS'(int'(cmd.start_y) + d);
				if ($urandom_range(0, 1))
					{cmd.start_y, cmd.end_y} = {cmd.end_y, cmd.start_y};
			end
			4, 5: begin
				cmd.end_x = near(cmd.start_x);
				cmd.end_y = near(cmd.start_y);
			end
			default: ;
		endcase
		return cmd;
	endfunction

	// Present one command from the falling edge and hold it until accepted
	task automatic drive_line(input blr_in_t cmd);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= cmd;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	initial begin
		// points, axis lines, diagonals, reversed and steep lines, colour extremes
		line_queue.push_back(make_line(0, 0, 0, 0, 32'h0000_0000));
		line_queue.push_back(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
		line_queue.push_back(make_line(0, 0, 63, 0, 32'hAAAA_AAAA));
		line_queue.push_back(make_line(63, 63, 0, 63, 32'h5555_5555));
		line_queue.push_back(make_line(0, 0, 0, 63, 32'h1234_5678));
		line_queue.push_back(make_line(5, 63, 5, 0, 32'h8765_4321));
		line_queue.push_back(make_line(0, 0, 63, 63, 32'hFF00_FF00));
		line_queue.push_back(make_line(63, 63, 0, 0, 32'h00FF_00FF));
		line_queue.push_back(make_line(0, 63, 63, 0, 32'hDEAD_BEEF));
		line_queue.push_back(make_line(63, 0, 0, 63, 32'hCAFE_F00D));
		line_queue.push_back(make_line(0, 0, 63, 31, 32'h0F0F_0F0F));
		line_queue.push_back(make_line(0, 63, 63, 32, 32'hF0F0_F0F0));
		line_queue.push_back(make_line(10, 0, 40, 63, 32'h8000_0001));
		line_queue.push_back(make_line(40, 0, 10, 63, 32'h7FFF_FFFE));
		line_queue.push_back(make_line(63, 10, 0, 20, 32'h0000_FFFF));
		line_queue.push_back(make_line(3, 7, 4, 7, 32'hFFFF_0000));
		line_queue.push_back(make_line(20, 20, 21, 22, 32'h3C3C_3C3C));
		line_queue.push_back(make_line(0, 0, 63, 1, 32'hC3C3_C3C3));
		line_queue.push_back(make_line(0, 0, 1, 63, 32'h0101_0101));
		line_queue.push_back(make_line(32, 33, 32, 32, 32'hFEFE_FEFE));
		directed_count = line_queue.size();
		repeat (RANDOM_LINES)
			line_queue.push_back(random_line());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Send in bursts of random length, with an idle gap before most of them
		burst_left = 0;
		foreach (line_queue[i]) begin
			if (burst_left == 0) begin
				gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				repeat (gap_len) begin
					@(negedge clk);
					in_valid <= 1'b0;
				end
				burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6);
			end
			drive_line(line_queue[i]);
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then allow stray pixels to show up
		while (pixels_pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		$display("covered %0d line commands (%0d directed, %0d random), %0d pixels compared",
			line_queue.size(), directed_count, line_queue.size() - directed_count, pixels_checked);
		$display("input sent in bursts with idle gaps, output stalled on changing patterns");
		if (fail_count == 0 && pixels_pending == 0) begin
			$display("bresenham_line_rasterizer_tb: clean");
		end else begin
			$display("bresenham_line_rasterizer_tb: errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * 1_500_000);
		$display("bresenham_line_rasterizer_tb: errors");
		$finish;
	end

endmodule
